// ===== hdl/cpu_alu_bcd_flags_macros.svh =====
// Assertion macros shared by the ALU block.
// Each macro expects clk and arst_n to be in scope where it is used.
`ifndef CPU_ALU_BCD_FLAGS_MACROS_SVH
`define CPU_ALU_BCD_FLAGS_MACROS_SVH

// Same-cycle implication, off during reset.
`define CAB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, off during reset.
`define CAB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hdl/cab_pkg.sv =====
// Shared types and constants for the eight-bit ALU with decimal mode.
// No dependencies; used by cab_core and cpu_alu_bcd_flags.
package cab_pkg;

	typedef enum logic [4:0] {
		OP_ADC = 5'd0,
		OP_SBC = 5'd1,
		OP_AND = 5'd2,
		OP_EOR = 5'd3,
		OP_ORA = 5'd4,
		OP_CMP = 5'd5,
		OP_INC = 5'd6,
		OP_DEC = 5'd7,
		OP_ASL = 5'd8,
		OP_LSR = 5'd9,
		OP_ROL = 5'd10,
		OP_ROR = 5'd11,
		OP_BIT = 5'd12,
		OP_TSB = 5'd13,
		OP_TRB = 5'd14,
		OP_TST = 5'd15,
		OP_RMB = 5'd16,
		OP_SMB = 5'd17,
		OP_BBR = 5'd18,
		OP_BBS = 5'd19
	} alu_op_t;

	// Incoming status flags.
	typedef struct packed {
		logic carry;
		logic decimal;
		logic overflow;
		logic zero;
		logic negative;
	} flags_in_t;

	// Outgoing status flags.
	typedef struct packed {
		logic carry;
		logic zero;
		logic negative;
		logic overflow;
	} flags_out_t;

	localparam logic [4:0] BCD_DIGIT_MAX = 5'h09;
	localparam logic [5:0] BCD_ADJ_LO    = 6'h06;
	localparam logic [3:0] BCD_SUB_LO    = 4'hA;
	localparam logic [9:0] BCD_HI_LIMIT  = 10'h09F;
	localparam logic [9:0] BCD_ADJ_HI    = 10'h060;
	localparam logic [9:0] BYTE_MAX      = 10'h0FF;
	localparam logic [7:0] BCD_SUB_HI    = 8'h60;

endpackage

// ===== hdl/cpu_alu_bcd_flags.sv =====
// Eight-bit CPU ALU with BCD mode: operand register, ALU logic, result register.
// An accepted beat passes through the operand register, then the result register, before it shows on the output.
// Throughput: one beat per cycle while the output is not stalled, set by the single operand/result register pair.
// Both stages have their own valid bit, so a new beat can enter an empty operand register while a result waits.
// Reset (arst_n low, asynchronous) clears both valid bits; payload registers keep no reset.
// Depends on cab_pkg, cab_core and cpu_alu_bcd_flags_macros.svh.
`include "cpu_alu_bcd_flags_macros.svh"

module cpu_alu_bcd_flags
	import cab_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [4:0] op,
	input  logic [7:0] left_operand,
	input  logic [7:0] right_operand,
	input  logic [2:0] bit_index,
	input  logic       carry_in,
	input  logic       decimal_in,
	input  logic       overflow_in,
	input  logic       zero_in,
	input  logic       negative_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] result_byte,
	output logic       carry_out,
	output logic       zero_out,
	output logic       negative_out,
	output logic       overflow_out,
	output logic       branch_taken
);

	logic       valid_s1;
	logic [4:0] op_s1;
	logic [7:0] left_s1;
	logic [7:0] right_s1;
	logic [2:0] bit_s1;
	flags_in_t  flags_s1;
	logic       ready_s2;

	logic [7:0] core_res;
	flags_out_t core_flags;
	logic       core_br;

	logic       valid_s2;
	logic [7:0] result_s2;
	flags_out_t flags_s2;
	logic       branch_s2;

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture the operand beat.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1             <= op;
			left_s1           <= left_operand;
			right_s1          <= right_operand;
			bit_s1            <= bit_index;
			flags_s1.carry    <= carry_in;
			flags_s1.decimal  <= decimal_in;
			flags_s1.overflow <= overflow_in;
			flags_s1.zero     <= zero_in;
			flags_s1.negative <= negative_in;
		end
	end

	cab_core u_core (
		.op            (alu_op_t'(op_s1)),
		.left_operand  (left_s1),
		.right_operand (right_s1),
		.bit_index     (bit_s1),
		.flags_in      (flags_s1),
		.result_byte   (core_res),
		.flags_out     (core_flags),
		.branch_taken  (core_br)
	);

	// Advance into the result register unless the output stalls.
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			result_s2 <= core_res;
			flags_s2  <= core_flags;
			branch_s2 <= core_br;
		end
	end

	assign out_valid    = valid_s2;
	assign result_byte  = result_s2;
	assign carry_out    = flags_s2.carry;
	assign zero_out     = flags_s2.zero;
	assign negative_out = flags_s2.negative;
	assign overflow_out = flags_s2.overflow;
	assign branch_taken = branch_s2;

	`CAB_ASSERT_IMP(a_empty_s1_ready, !valid_s1, in_ready)
	`CAB_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, valid_s1)
	`CAB_ASSERT_NEXT(a_s1_moves_to_out, valid_s1 && ready_s2, out_valid)
	`CAB_ASSERT_NEXT(a_stall_holds_result, valid_s2 && !out_ready, valid_s2 && $stable(result_s2))
	`CAB_ASSERT_IMP(a_branch_only_bb, valid_s1 && core_br, op_s1 == OP_BBR || op_s1 == OP_BBS)

endmodule

// ===== hdl/cab_core.sv =====
// Combinational operation decode, binary/BCD adder and flag logic.
// Depends on cab_pkg.
module cab_core
	import cab_pkg::*;
(
	input  alu_op_t    op,
	input  logic [7:0] left_operand,
	input  logic [7:0] right_operand,
	input  logic [2:0] bit_index,
	input  flags_in_t  flags_in,
	output logic [7:0] result_byte,
	output flags_out_t flags_out,
	output logic       branch_taken
);

	logic       sub;
	logic [7:0] r_eff;
	logic [8:0] bin_sum;
	logic       bin_v;
	logic [4:0] lo_raw;
	logic [5:0] lo_adc;
	logic       half_adc;
	logic [9:0] hi_adc;
	logic [9:0] hi_adc_adj;
	logic [3:0] lo_sbc;
	logic [8:0] hi_sbc;
	logic [7:0] add_res;
	logic       add_c;
	logic [8:0] cmp_diff;
	logic [7:0] mask;
	logic [7:0] res;
	logic       c;
	logic       z;
	logic       n;
	logic       v;
	logic       br;
	logic       set_zn;

	// Adder shared by adc and sbc; sbc adds the inverted right byte.
	always_comb begin
		sub      = (op == OP_SBC);
		r_eff    = sub ? ~right_operand : right_operand;
		bin_sum  = {1'b0, left_operand} + {1'b0, r_eff} + {8'b0, flags_in.carry};
		bin_v    = ~(left_operand[7] ^ r_eff[7]) & (left_operand[7] ^ bin_sum[7]);
		lo_raw   = {1'b0, left_operand[3:0]} + {1'b0, r_eff[3:0]} + {4'b0, flags_in.carry};

		lo_adc   = (lo_raw > BCD_DIGIT_MAX) ? ({1'b0, lo_raw} + BCD_ADJ_LO) : {1'b0, lo_raw};
		half_adc = (lo_adc[5:4] != 2'b00);
		hi_adc   = {2'b0, left_operand[7:4], 4'b0} + {2'b0, r_eff[7:4], 4'b0}
			+ {5'b0, half_adc, 4'b0} + {6'b0, lo_adc[3:0]};
		hi_adc_adj = (hi_adc > BCD_HI_LIMIT) ? (hi_adc + BCD_ADJ_HI) : hi_adc;

		// no half carry: drop 6 from the low digit, modulo 16
		lo_sbc   = lo_raw[4] ? lo_raw[3:0] : (lo_raw[3:0] + BCD_SUB_LO);
		hi_sbc   = {1'b0, left_operand[7:4], 4'b0} + {1'b0, r_eff[7:4], 4'b0}
			+ {4'b0, lo_raw[4], 4'b0} + {5'b0, lo_sbc};

		if (!flags_in.decimal) begin
			add_res = bin_sum[7:0];
			add_c   = bin_sum[8];
		end else if (!sub) begin
			add_res = hi_adc_adj[7:0];
			add_c   = (hi_adc_adj > BYTE_MAX);
		end else begin
			add_c   = hi_sbc[8];
			add_res = add_c ? hi_sbc[7:0] : (hi_sbc[7:0] - BCD_SUB_HI);
		end
	end

	always_comb begin
		cmp_diff = {1'b0, left_operand} - {1'b0, right_operand};
		mask     = 8'b1 << bit_index;
		res      = left_operand;
		c        = flags_in.carry;
		z        = flags_in.zero;
		n        = flags_in.negative;
		v        = flags_in.overflow;
		br       = 1'b0;
		set_zn   = 1'b0;
		unique case (op)
			OP_ADC, OP_SBC: begin
				res    = add_res;
				c      = add_c;
				set_zn = 1'b1;
				if (!flags_in.decimal) begin
					v = bin_v;
				end
			end
			OP_AND: begin
				res    = left_operand & right_operand;
				set_zn = 1'b1;
			end
			OP_EOR: begin
				res    = left_operand ^ right_operand;
				set_zn = 1'b1;
			end
			OP_ORA: begin
				res    = left_operand | right_operand;
				set_zn = 1'b1;
			end
			OP_CMP: begin
				c = ~cmp_diff[8];
				z = (left_operand == right_operand);
				n = cmp_diff[7];
			end
			OP_INC: begin
				res    = left_operand + 8'd1;
				set_zn = 1'b1;
			end
			OP_DEC: begin
				res    = left_operand - 8'd1;
				set_zn = 1'b1;
			end
			OP_ASL: begin
				res    = {left_operand[6:0], 1'b0};
				c      = left_operand[7];
				set_zn = 1'b1;
			end
			OP_LSR: begin
				res    = {1'b0, left_operand[7:1]};
				c      = left_operand[0];
				set_zn = 1'b1;
			end
			OP_ROL: begin
				res    = {left_operand[6:0], flags_in.carry};
				c      = left_operand[7];
				set_zn = 1'b1;
			end
			OP_ROR: begin
				res    = {flags_in.carry, left_operand[7:1]};
				c      = left_operand[0];
				set_zn = 1'b1;
			end
			OP_BIT: begin
				z = ((left_operand & right_operand) == 8'h00);
				v = right_operand[6];
				n = right_operand[7];
			end
			OP_TSB: begin
				res = left_operand | right_operand;
				v   = left_operand[6];
				n   = left_operand[7];
				z   = ((left_operand | right_operand) == 8'h00);
			end
			OP_TRB: begin
				res = left_operand & ~right_operand;
				v   = left_operand[6];
				n   = left_operand[7];
				z   = ((left_operand & ~right_operand) == 8'h00);
			end
			OP_TST: begin
				v = left_operand[6];
				n = left_operand[7];
				z = ((left_operand & right_operand) == 8'h00);
			end
			OP_RMB: res = left_operand & ~mask;
			OP_SMB: res = left_operand | mask;
			OP_BBR: br = ((left_operand & mask) == 8'h00);
			OP_BBS: br = ((left_operand & mask) != 8'h00);
			default: ;
		endcase
		if (set_zn) begin
			z = (res == 8'h00);
			n = res[7];
		end
	end

	assign result_byte        = res;
	assign flags_out.carry    = c;
	assign flags_out.zero     = z;
	assign flags_out.negative = n;
	assign flags_out.overflow = v;
	assign branch_taken       = br;

endmodule
